[rtl/core/pct_pkg.sv]
// Shared types, constants and sizes for the pitch calibration table.
package pct_pkg;

  // Table geometry.
  localparam int CHANNELS = 4;
  localparam int OCTAVES  = 10;
  localparam int SEMIS    = 12;
  localparam int SLOTS    = OCTAVES * SEMIS;
  localparam int DEPTH    = CHANNELS * SLOTS;
  localparam int DAC_MAX  = 16383;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DAC_W   = $clog2(DAC_MAX + 1);
  localparam int OCT_W   = $clog2(OCTAVES);
  localparam int K_W     = $clog2(SEMIS);
  localparam int CV_W    = 15;

  // Equal temperament: ET(s) = floor(s * ET_SCALE / ET_DIV), built incrementally.
  localparam int ET_SCALE = 16384;
  localparam int ET_DIV   = 120;
  localparam int ET_INC   = ET_SCALE / ET_DIV;
  localparam int ET_FRAC  = ET_SCALE % ET_DIV;
  localparam int ET_W     = $clog2(((SLOTS - 1) * ET_SCALE) / ET_DIV + 1);
  localparam int REM_W    = $clog2(ET_DIV);

  // Q16.16 interpolation.
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;
  localparam int ACC_W      = DAC_W + 18;
  localparam int STEP_W     = DAC_W + 14;

  // delta * 65536 / 12 is worked as (delta / 3) * 16384 plus a remainder term.
  localparam int DIV3_MUL  = 43691;
  localparam int DIV3_SH   = 17;
  localparam int STEP_SH   = 14;
  localparam int STEP_FRAC = (1 << STEP_SH) / 3;
  localparam int PROD_W    = DAC_W + DIV3_SH;

  // Item modes.
  localparam logic [2:0] MODE_RELOAD = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_NOTE   = 3'd3;
  localparam logic [2:0] MODE_OFFSET = 3'd4;
  localparam logic [2:0] MODE_INTERP = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         channel;
    logic [7:0]         slot;
    logic [15:0]        dac_value;
    logic signed [15:0] note;
  } in_item_t;

  typedef struct packed {
    logic signed [CV_W-1:0] cv_value;
    logic                   write_dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_SUM,
    ALU_ROUND
  } alu_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ET,
    S_WR,
    S_RD,
    S_RDD,
    S_OF_RD,
    S_OF_WR,
    S_IP_RLO,
    S_IP_RHI,
    S_IP_DLT,
    S_IP_SLP,
    S_IP_FILL,
    S_DONE
  } state_e;

endpackage

[rtl/core/pct_ram.sv]
// Single-port table memory with a registered read port.
module pct_ram #(
  parameter int DEPTH  = 480,
  parameter int WIDTH  = 14,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // The read word holds until the next read, so writes do not disturb it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pct_alu.sv]
// Shared add, round and saturate unit that produces every value written to the table.
module pct_alu (
  input  pct_pkg::alu_op_e                 op_i,
  input  logic signed [pct_pkg::ACC_W-1:0] a_i,
  input  logic signed [pct_pkg::ACC_W-1:0] b_i,
  output logic [pct_pkg::DAC_W-1:0]        y_o
);

  logic signed [pct_pkg::ACC_W-1:0] sum;
  logic signed [pct_pkg::ACC_W-1:0] val;

  assign sum = a_i + b_i;

  always_comb begin
    unique case (op_i)
      pct_pkg::ALU_ROUND: begin
        // A negative accumulator does not round; it always clamps to zero.
        val = (a_i < 0) ? '0 : (sum >>> pct_pkg::FRAC_BITS);
      end
      default: begin
        val = sum;
      end
    endcase
  end

  always_comb begin
    if (val < 0) begin
      y_o = '0;
    end else if (val > $signed(pct_pkg::ACC_W'(pct_pkg::DAC_MAX))) begin
      y_o = pct_pkg::DAC_W'(pct_pkg::DAC_MAX);
    end else begin
      y_o = val[pct_pkg::DAC_W-1:0];
    end
  end

endmodule

[rtl/core/pct_slope.sv]
// Two-stage slope unit: step = trunc(delta * 65536 / 12) by reciprocal multiply.
module pct_slope (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [pct_pkg::DAC_W:0]    delta_i,
  output logic signed [pct_pkg::STEP_W-1:0] step_o
);

  logic                              neg;
  logic signed [pct_pkg::DAC_W:0]    delta_neg;
  logic [pct_pkg::DAC_W-1:0]         mag;
  logic [pct_pkg::PROD_W-1:0]        prod_q;
  logic [pct_pkg::DAC_W-1:0]         mag_q;
  logic                              neg_q;
  logic [pct_pkg::DAC_W-1:0]         quo;
  logic [pct_pkg::DAC_W+1:0]         quo3;
  logic [pct_pkg::DAC_W-1:0]         rem_full;
  logic [1:0]                        rem;
  logic signed [pct_pkg::STEP_W-1:0] step_mag;

  assign neg       = delta_i[pct_pkg::DAC_W];
  assign delta_neg = -delta_i;
  assign mag       = neg ? delta_neg[pct_pkg::DAC_W-1:0] : delta_i[pct_pkg::DAC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= pct_pkg::PROD_W'(mag) * pct_pkg::PROD_W'(pct_pkg::DIV3_MUL);
      mag_q  <= mag;
      neg_q  <= neg;
    end
  end

  // The magnitude is split into 3*quo + rem; rem in 0..2 adds rem*16384/3.
  assign quo      = prod_q[pct_pkg::DIV3_SH +: pct_pkg::DAC_W];
  assign quo3     = (pct_pkg::DAC_W + 2)'(quo) * (pct_pkg::DAC_W + 2)'(3);
  assign rem_full = mag_q - quo3[pct_pkg::DAC_W-1:0];
  assign rem      = rem_full[1:0];

  assign step_mag = $signed((pct_pkg::STEP_W'(quo) << pct_pkg::STEP_SH)
                  + pct_pkg::STEP_W'(rem) * pct_pkg::STEP_W'(pct_pkg::STEP_FRAC));
  assign step_o   = neg_q ? -step_mag : step_mag;

endmodule

[rtl/core/pitch_calibration_table.sv]
// Pitch calibration table: per-channel semitone-to-DAC store with sequenced refits.
// Items: write, read, note-to-cv, reload, offset fit and interpolate fit; every entry
// of a sweep goes through the single table port.
// One word is in work at a time; in_ready_o returns once the result is loaded.
// After reset the table is filled with equal temperament.
module pitch_calibration_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pct_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pct_pkg::out_item_t out_data_o
);

  pct_pkg::state_e state_q, state_d;

  // Sweep and access counters.
  logic [pct_pkg::ADDR_W-1:0] addr_q;
  logic [pct_pkg::SLOT_W-1:0] s_q;
  logic [pct_pkg::CH_W-1:0]   ch_q;
  logic [pct_pkg::ET_W-1:0]   et_q;
  logic [pct_pkg::REM_W-1:0]  rem_q;
  logic [pct_pkg::K_W-1:0]    k_q;
  logic [pct_pkg::OCT_W-1:0]  o_q;

  // Word and interpolation registers.
  logic [15:0]                        dac_q;
  logic                               drop_q;
  logic                               neg_q;
  logic [pct_pkg::DAC_W-1:0]          wlo_q;
  logic signed [pct_pkg::ACC_W-1:0]   acc_q;
  logic signed [pct_pkg::STEP_W-1:0]  step_q;

  logic                out_valid_q, out_valid_d;
  pct_pkg::out_item_t  out_data_q, out_data_d;

  logic                               in_fire;
  logic                               out_free;
  logic                               out_load;
  logic                               last_slot;
  logic                               last_entry;
  logic                               last_oct;
  logic                               last_k;
  logic                               adv;
  logic                               slope_en;
  logic                               ram_we;
  logic                               ram_re;
  logic [pct_pkg::ADDR_W-1:0]         ram_addr;
  logic [pct_pkg::DAC_W-1:0]          ram_rdata;
  pct_pkg::alu_op_e                   alu_op;
  logic signed [pct_pkg::ACC_W-1:0]   alu_a;
  logic signed [pct_pkg::ACC_W-1:0]   alu_b;
  logic [pct_pkg::DAC_W-1:0]          alu_y;
  logic signed [pct_pkg::DAC_W:0]     delta;
  logic signed [pct_pkg::STEP_W-1:0]  slope_step;
  logic signed [pct_pkg::CV_W:0]      entry_s;

  // Address of a single access, with channel and slot clamped.
  logic                               in_drop;
  logic [pct_pkg::CH_W-1:0]           ch_cl;
  logic [pct_pkg::SLOT_W-1:0]         slot_cl;
  logic [pct_pkg::SLOT_W-1:0]         note_cl;
  logic [pct_pkg::SLOT_W-1:0]         slot_sel;
  logic signed [16:0]                 note_x;
  logic signed [16:0]                 note_neg;
  logic [15:0]                        note_mag;
  logic [pct_pkg::ADDR_W-1:0]         in_addr;

  logic [pct_pkg::REM_W:0]            rem_sum;
  logic                               rem_carry;

  assign in_ready_o = (state_q == pct_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign last_slot  = (s_q == pct_pkg::SLOT_W'(pct_pkg::SLOTS - 1));
  assign last_entry = last_slot && (ch_q == pct_pkg::CH_W'(pct_pkg::CHANNELS - 1));
  assign last_oct   = (o_q == pct_pkg::OCT_W'(pct_pkg::OCTAVES - 1));
  assign last_k     = (k_q == pct_pkg::K_W'(pct_pkg::SEMIS - 1));

  assign in_drop  = (in_data_i.channel >= 8'(pct_pkg::CHANNELS))
                 || (in_data_i.slot >= 8'(pct_pkg::SLOTS));
  assign ch_cl    = (in_data_i.channel >= 8'(pct_pkg::CHANNELS))
                  ? pct_pkg::CH_W'(pct_pkg::CHANNELS - 1)
                  : in_data_i.channel[pct_pkg::CH_W-1:0];
  assign slot_cl  = (in_data_i.slot >= 8'(pct_pkg::SLOTS))
                  ? pct_pkg::SLOT_W'(pct_pkg::SLOTS - 1)
                  : in_data_i.slot[pct_pkg::SLOT_W-1:0];
  assign note_x   = {in_data_i.note[15], in_data_i.note};
  assign note_neg = -note_x;
  assign note_mag = in_data_i.note[15] ? note_neg[15:0] : note_x[15:0];
  assign note_cl  = (note_mag >= 16'(pct_pkg::SLOTS))
                  ? pct_pkg::SLOT_W'(pct_pkg::SLOTS - 1)
                  : note_mag[pct_pkg::SLOT_W-1:0];
  assign slot_sel = (in_data_i.mode == pct_pkg::MODE_NOTE) ? note_cl : slot_cl;
  assign in_addr  = pct_pkg::ADDR_W'(ch_cl) * pct_pkg::ADDR_W'(pct_pkg::SLOTS)
                  + pct_pkg::ADDR_W'(slot_sel);

  assign rem_sum   = (pct_pkg::REM_W + 1)'(rem_q) + (pct_pkg::REM_W + 1)'(pct_pkg::ET_FRAC);
  assign rem_carry = (rem_sum >= (pct_pkg::REM_W + 1)'(pct_pkg::ET_DIV));

  assign delta   = $signed({1'b0, ram_rdata}) - $signed({1'b0, wlo_q});
  assign entry_s = $signed({1'b0, pct_pkg::CV_W'(ram_rdata)});

  pct_ram #(
    .DEPTH  (pct_pkg::DEPTH),
    .WIDTH  (pct_pkg::DAC_W),
    .ADDR_W (pct_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (alu_y),
    .rdata_o (ram_rdata)
  );

  pct_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  pct_slope u_slope (
    .clk_i   (clk_i),
    .en_i    (slope_en),
    .delta_i (delta),
    .step_o  (slope_step)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      pct_pkg::S_INIT: begin
        if (last_entry) state_d = pct_pkg::S_IDLE;
      end
      pct_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.mode) inside
            pct_pkg::MODE_RELOAD: state_d = pct_pkg::S_ET;
            pct_pkg::MODE_WRITE:  state_d = pct_pkg::S_WR;
            pct_pkg::MODE_READ,
            pct_pkg::MODE_NOTE:   state_d = pct_pkg::S_RD;
            pct_pkg::MODE_OFFSET: state_d = pct_pkg::S_OF_RD;
            pct_pkg::MODE_INTERP: state_d = pct_pkg::S_IP_RLO;
            default:              state_d = pct_pkg::S_DONE;
          endcase
        end
      end
      pct_pkg::S_ET: begin
        if (last_entry) state_d = pct_pkg::S_DONE;
      end
      pct_pkg::S_RD: state_d = pct_pkg::S_RDD;
      pct_pkg::S_WR, pct_pkg::S_RDD, pct_pkg::S_DONE: begin
        if (out_free) state_d = pct_pkg::S_IDLE;
      end
      pct_pkg::S_OF_RD: state_d = pct_pkg::S_OF_WR;
      pct_pkg::S_OF_WR: begin
        if (last_entry)     state_d = pct_pkg::S_DONE;
        else if (last_slot) state_d = pct_pkg::S_OF_RD;
      end
      pct_pkg::S_IP_RLO: state_d = pct_pkg::S_IP_RHI;
      pct_pkg::S_IP_RHI: state_d = last_oct ? pct_pkg::S_IP_FILL : pct_pkg::S_IP_DLT;
      pct_pkg::S_IP_DLT: state_d = pct_pkg::S_IP_SLP;
      pct_pkg::S_IP_SLP: state_d = pct_pkg::S_IP_FILL;
      pct_pkg::S_IP_FILL: begin
        if (last_k) state_d = last_entry ? pct_pkg::S_DONE : pct_pkg::S_IP_RLO;
      end
      default: state_d = pct_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and the result word.
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = addr_q;
    alu_op     = pct_pkg::ALU_SUM;
    alu_a      = $signed(pct_pkg::ACC_W'(et_q));
    alu_b      = '0;
    adv        = 1'b0;
    slope_en   = 1'b0;
    out_load   = 1'b0;
    out_data_d = '0;
    unique case (state_q) inside
      pct_pkg::S_INIT, pct_pkg::S_ET: begin
        ram_we = 1'b1;
        adv    = 1'b1;
      end
      pct_pkg::S_WR: begin
        // Repeating the write while the result waits leaves the same value.
        ram_we                   = !drop_q;
        alu_a                    = $signed(pct_pkg::ACC_W'(dac_q));
        out_load                 = out_free;
        out_data_d.write_dropped = drop_q;
      end
      pct_pkg::S_RD, pct_pkg::S_OF_RD, pct_pkg::S_IP_RLO: begin
        ram_re = 1'b1;
      end
      pct_pkg::S_RDD: begin
        out_load            = out_free;
        out_data_d.cv_value = neg_q ? pct_pkg::CV_W'(-entry_s) : pct_pkg::CV_W'(entry_s);
      end
      pct_pkg::S_DONE: begin
        out_load = out_free;
      end
      pct_pkg::S_OF_WR: begin
        // The row's slot-0 value stays in the read register for the whole row.
        ram_we = 1'b1;
        alu_b  = $signed(pct_pkg::ACC_W'(ram_rdata));
        adv    = 1'b1;
      end
      pct_pkg::S_IP_RHI: begin
        ram_re   = !last_oct;
        ram_addr = addr_q + pct_pkg::ADDR_W'(pct_pkg::SEMIS);
      end
      pct_pkg::S_IP_DLT: begin
        slope_en = 1'b1;
      end
      pct_pkg::S_IP_FILL: begin
        ram_we = 1'b1;
        alu_op = pct_pkg::ALU_ROUND;
        alu_a  = acc_q;
        alu_b  = $signed(pct_pkg::ACC_W'(pct_pkg::ROUND_HALF));
        adv    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pct_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  // Counters: the power-up fill sweep starts from the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      s_q    <= '0;
      ch_q   <= '0;
      et_q   <= '0;
      rem_q  <= '0;
      k_q    <= '0;
      o_q    <= '0;
    end else if (in_fire) begin
      addr_q <= (in_data_i.mode == pct_pkg::MODE_RELOAD
              || in_data_i.mode == pct_pkg::MODE_OFFSET
              || in_data_i.mode == pct_pkg::MODE_INTERP) ? '0 : in_addr;
      s_q    <= '0;
      ch_q   <= '0;
      et_q   <= '0;
      rem_q  <= '0;
      k_q    <= '0;
      o_q    <= '0;
    end else if (adv) begin
      addr_q <= addr_q + 1'b1;
      if (last_slot) begin
        s_q   <= '0;
        ch_q  <= ch_q + 1'b1;
        et_q  <= '0;
        rem_q <= '0;
      end else begin
        s_q   <= s_q + 1'b1;
        et_q  <= et_q + pct_pkg::ET_W'(pct_pkg::ET_INC) + pct_pkg::ET_W'(rem_carry);
        rem_q <= rem_carry ? pct_pkg::REM_W'(rem_sum - (pct_pkg::REM_W + 1)'(pct_pkg::ET_DIV))
                           : rem_sum[pct_pkg::REM_W-1:0];
      end
      if (state_q == pct_pkg::S_IP_FILL) begin
        if (last_k) begin
          k_q <= '0;
          o_q <= last_oct ? '0 : o_q + 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dac_q  <= in_data_i.dac_value;
      drop_q <= (in_data_i.mode == pct_pkg::MODE_WRITE) && in_drop;
      neg_q  <= (in_data_i.mode == pct_pkg::MODE_NOTE) && in_data_i.note[15];
    end
    if (state_q == pct_pkg::S_IP_RHI) begin
      wlo_q <= ram_rdata;
      acc_q <= $signed(pct_pkg::ACC_W'(ram_rdata) << pct_pkg::FRAC_BITS);
    end else if (state_q == pct_pkg::S_IP_FILL) begin
      acc_q <= acc_q + pct_pkg::ACC_W'(step_q);
    end
    if (state_q == pct_pkg::S_IP_SLP) begin
      step_q <= slope_step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/pct_checker.sv]
// Port-level checks for the pitch calibration table, bound to the top level.
module pct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pct_pkg::out_item_t out_data_o
);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  // The block works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a word is in work");

  // A new result only appears at the end of a word's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

  // A dropped write carries no cv.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_dropped |-> out_data_o.cv_value == '0)
    else $error("dropped write returned a nonzero cv");

endmodule

bind pitch_calibration_table pct_checker u_pct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
